/* hw/rtl/mltv_pkg.sv */
// ----------------------------------------------------------------------------
// mltv_pkg
// Shared constants and types for the map line token validator: operation,
// status and parse phase codes, character codes and the parser result bundle.
// ----------------------------------------------------------------------------
package mltv_pkg;

	// Counter widths of the line and row state
	localparam int COUNT_BITS = 12;
	localparam int ROW_BITS   = 16;

	// Fixed widths of the item fields
	localparam int OP_W      = 2;
	localparam int CHAR_W    = 8;
	localparam int STATUS_W  = 2;
	localparam int COLUMNS_W = 12;
	localparam int ROWS_W    = 16;

	localparam int PHASE_W = 4;
	localparam int HEX_W   = 3;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CHAR = 2'd0;
	localparam logic [OP_W-1:0] OP_EOL  = 2'd1;
	localparam logic [OP_W-1:0] OP_NEW  = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SYNTAX   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd3;

	// Parse phases
	localparam logic [PHASE_W-1:0] PH_START  = 4'd0;
	localparam logic [PHASE_W-1:0] PH_LEAD   = 4'd1;
	localparam logic [PHASE_W-1:0] PH_SIGN   = 4'd2;
	localparam logic [PHASE_W-1:0] PH_DIGITS = 4'd3;
	localparam logic [PHASE_W-1:0] PH_COMMA  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_ZERO   = 4'd5;
	localparam logic [PHASE_W-1:0] PH_HEX    = 4'd6;
	localparam logic [PHASE_W-1:0] PH_GAP    = 4'd7;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UC_F  = 8'h46;

	// Legal colour digit counts
	localparam logic [HEX_W-1:0] HEX_LEN_2 = 3'd2;
	localparam logic [HEX_W-1:0] HEX_LEN_4 = 3'd4;
	localparam logic [HEX_W-1:0] HEX_LEN_6 = 3'd6;
	localparam logic [HEX_W-1:0] HEX_SAT   = 3'd7;

	// Outcome of one character step
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [HEX_W-1:0]   hex_cnt;
		logic               count_tok;
		logic               fail;
		logic               end_ok;
	} parse_t;

endpackage

/* hw/rtl/mltv_parse.sv */
// ----------------------------------------------------------------------------
// mltv_parse
// Character classifier and token phase logic: next phase, colour digit count,
// token start and syntax failure for one character, plus end-of-line check.
// ----------------------------------------------------------------------------
module mltv_parse (
	input  logic [mltv_pkg::PHASE_W-1:0] phase,
	input  logic [mltv_pkg::HEX_W-1:0]   hex_cnt,
	input  logic [mltv_pkg::CHAR_W-1:0]  char_code,
	output mltv_pkg::parse_t             result
);
	import mltv_pkg::*;

	logic is_dec;
	logic is_hex;
	logic len_ok;

	assign is_dec = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_hex = is_dec || ((char_code >= CH_LC_A) && (char_code <= CH_LC_F)) ||
		((char_code >= CH_UC_A) && (char_code <= CH_UC_F));
	assign len_ok = (hex_cnt == HEX_LEN_2) || (hex_cnt == HEX_LEN_4) ||
		(hex_cnt == HEX_LEN_6);

	always_comb begin
		result.phase     = phase;
		result.hex_cnt   = hex_cnt;
		result.count_tok = 1'b0;
		result.fail      = 1'b0;
		case (phase)
			PH_START, PH_LEAD, PH_GAP: begin
				if (char_code == CH_SPACE) begin
					if (phase == PH_START) begin
						result.phase = PH_LEAD;
					end
				end else if (char_code == CH_MINUS) begin
					result.count_tok = 1'b1;
					result.phase     = PH_SIGN;
				end else if (is_dec) begin
					result.count_tok = 1'b1;
					result.phase     = PH_DIGITS;
				end else begin
					result.fail = 1'b1;
				end
			end
			PH_SIGN: begin
				if (is_dec) begin
					result.phase = PH_DIGITS;
				end else begin
					result.fail = 1'b1;
				end
			end
			PH_DIGITS: begin
				if (char_code == CH_COMMA) begin
					result.phase = PH_COMMA;
				end else if (char_code == CH_SPACE) begin
					result.phase = PH_GAP;
				end else if (!is_dec) begin
					result.fail = 1'b1;
				end
			end
			PH_COMMA: begin
				if (char_code == CH_ZERO) begin
					result.phase = PH_ZERO;
				end else begin
					result.fail = 1'b1;
				end
			end
			PH_ZERO: begin
				if (char_code == CH_X) begin
					result.hex_cnt = '0;
					result.phase   = PH_HEX;
				end else begin
					result.fail = 1'b1;
				end
			end
			PH_HEX: begin
				if (is_hex) begin
					// saturate so an overlong colour stays illegal
					if (hex_cnt != HEX_SAT) begin
						result.hex_cnt = hex_cnt + 1'b1;
					end
				end else if ((char_code == CH_SPACE) && len_ok) begin
					result.phase = PH_GAP;
				end else begin
					result.fail = 1'b1;
				end
			end
			default: begin
				result.fail = 1'b1;
			end
		endcase

		case (phase)
			PH_START, PH_DIGITS, PH_GAP: result.end_ok = 1'b1;
			PH_HEX:                      result.end_ok = len_ok;
			default:                     result.end_ok = 1'b0;
		endcase
	end

endmodule

/* hw/rtl/map_line_token_validator_core.sv */
// ----------------------------------------------------------------------------
// map_line_token_validator_core
// Throughput: one item (character, end of line or new map) per cycle, back to back, except
// while an end of line waits for room in a stalled, full result register.
// Path: an end-of-line item passes the input register, then the parser, then the result
// register, from which it transfers out.
// Reset: arst_n clears the line state, row count, first-row width and all valids.
// ----------------------------------------------------------------------------
module map_line_token_validator_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// item channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [mltv_pkg::OP_W-1:0]        operation,
	input  logic [mltv_pkg::CHAR_W-1:0]      char_code,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [mltv_pkg::STATUS_W-1:0]    status,
	output logic [mltv_pkg::COLUMNS_W-1:0]   columns,
	output logic [mltv_pkg::ROWS_W-1:0]      rows
);
	import mltv_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [ROW_BITS-1:0]   ROW_MAX   = '1;

	// Input register
	logic               valid_s1;
	logic [OP_W-1:0]    op_s1;
	logic [CHAR_W-1:0]  char_s1;

	// Line and map state
	logic [PHASE_W-1:0]    phase_q;
	logic [HEX_W-1:0]      hex_cnt_q;
	logic [COUNT_BITS-1:0] token_count_q;
	logic [COUNT_BITS-1:0] first_width_q;
	logic [ROW_BITS-1:0]   row_count_q;
	logic                  line_failed_q;
	logic                  token_ovf_q;

	// Result register
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [COLUMNS_W-1:0] columns_q;
	logic [ROWS_W-1:0]    rows_q;

	parse_t              parse;
	logic                adv_s1;
	logic                eol_s1;
	logic [STATUS_W-1:0] status_d;
	logic [ROW_BITS-1:0] row_next;

	mltv_parse u_parse (
		.phase     (phase_q),
		.hex_cnt   (hex_cnt_q),
		.char_code (char_s1),
		.result    (parse)
	);

	// Only an end of line produces a result; it needs room in the result register.
	assign eol_s1   = (op_s1 == OP_EOL);
	assign adv_s1   = valid_s1 && (!eol_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	// Capture the next item whenever the input register drains or is empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= operation;
			char_s1 <= char_code;
		end
	end

	// End-of-line verdict: syntax beats overflow, overflow beats mismatch.
	always_comb begin
		if (line_failed_q || !parse.end_ok) begin
			status_d = ST_SYNTAX;
		end else if (token_ovf_q) begin
			status_d = ST_TOO_MANY;
		end else if ((row_count_q != '0) && (token_count_q != first_width_q)) begin
			status_d = ST_MISMATCH;
		end else begin
			status_d = ST_OK;
		end
	end

	// Accepted rows saturate at full scale.
	assign row_next = (status_d == ST_OK && row_count_q != ROW_MAX) ?
		row_count_q + 1'b1 : row_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_START;
			hex_cnt_q     <= '0;
			token_count_q <= '0;
			first_width_q <= '0;
			row_count_q   <= '0;
			line_failed_q <= 1'b0;
			token_ovf_q   <= 1'b0;
		end else if (adv_s1) begin
			case (op_s1)
				OP_CHAR: begin
					// a failed line ignores everything up to its end
					if (!line_failed_q) begin
						phase_q   <= parse.phase;
						hex_cnt_q <= parse.hex_cnt;
						if (parse.fail) begin
							line_failed_q <= 1'b1;
						end
						if (parse.count_tok) begin
							if (token_count_q == COUNT_MAX) begin
								token_ovf_q <= 1'b1;
							end else begin
								token_count_q <= token_count_q + 1'b1;
							end
						end
					end
				end
				OP_EOL: begin
					// the first accepted row fixes the map width
					if ((status_d == ST_OK) && (row_count_q == '0)) begin
						first_width_q <= token_count_q;
					end
					row_count_q   <= row_next;
					phase_q       <= PH_START;
					hex_cnt_q     <= '0;
					token_count_q <= '0;
					line_failed_q <= 1'b0;
					token_ovf_q   <= 1'b0;
				end
				OP_NEW: begin
					first_width_q <= '0;
					row_count_q   <= '0;
					phase_q       <= PH_START;
					hex_cnt_q     <= '0;
					token_count_q <= '0;
					line_failed_q <= 1'b0;
					token_ovf_q   <= 1'b0;
				end
				default: begin
					// unused operation code: drop the item
				end
			endcase
		end
	end

	// Result register: load on an end of line, clear once the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && eol_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && eol_s1) begin
			status_q  <= status_d;
			columns_q <= COLUMNS_W'(token_count_q);
			rows_q    <= ROWS_W'(row_next);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign columns   = columns_q;
	assign rows      = rows_q;

`ifndef ASSERT_OFF
	// A line failure sticks until the line is closed or the map restarts.
	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(line_failed_q && !(adv_s1 && (op_s1 == OP_EOL || op_s1 == OP_NEW)))
		|=> line_failed_q)
		else $error("line failure cleared mid-line");

	// Overflow is only flagged with the token counter pinned at full scale.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		token_ovf_q |-> (token_count_q == COUNT_MAX))
		else $error("token overflow with counter below full scale");

	// No row accepted means no recorded first-row width.
	a_width_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(row_count_q == '0) |-> (first_width_q == '0))
		else $error("first-row width set with no accepted row");

	// A stall toward the source only ever comes from a held item.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && eol_s1 && out_valid_q))
		else $error("input stalled without a blocked end of line");
`endif

endmodule

/* dv/tb_map_line_token_validator_core.sv */
// ----------------------------------------------------------------------------
// tb_map_line_token_validator_core
// Character-level test of the map line token validator. A line predictor
// built into the scoreboard class tracks every transfer on the item channel
// and queues the expected end-of-line verdict. Each transfer on the result
// channel is checked field by field against the oldest queued verdict.
// Stimulus runs in this order: directed corner lines, random lines
// (well-formed, broken and noise), and a short closing stretch of empty,
// mismatched, broken and well-formed rows. Both channels idle in random
// bursts except in the closing stretch.
// ----------------------------------------------------------------------------
module tb_map_line_token_validator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import mltv_pkg::*;

	localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;  // undefined operation, dropped by the block
	localparam int LATENCY        = 2;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS   = 1340;
	localparam int REPORT_CAP     = 20;

	// One end-of-line verdict as it leaves the block
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [COLUMNS_W-1:0] columns;
		logic [ROWS_W-1:0]    rows;
	} verdict_t;

	// ------------------------------------------------------------------------
	// Scoreboard: line predictor plus queue of pending verdicts
	// ------------------------------------------------------------------------
	class line_verdict_board;
		logic [PHASE_W-1:0]    phase;
		logic [HEX_W-1:0]      hex_cnt;
		logic [COUNT_BITS-1:0] tok_cnt;
		logic [COUNT_BITS-1:0] first_width;
		logic [ROW_BITS-1:0]   row_cnt;
		bit                    line_bad;
		bit                    tok_over;
		verdict_t              verdict_q[$];
		int                    mismatches;
		int                    checked;
		int                    seen[4];

		function new();
			reset_line();
			first_width = '0;
			row_cnt     = '0;
			mismatches  = 0;
			checked     = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		function void reset_line();
			phase    = PH_START;
			hex_cnt  = '0;
			tok_cnt  = '0;
			line_bad = 1'b0;
			tok_over = 1'b0;
		endfunction

		function bit is_dec(logic [CHAR_W-1:0] c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		function bit is_hex(logic [CHAR_W-1:0] c);
			return is_dec(c) || (c >= CH_LC_A && c <= CH_LC_F) ||
				(c >= CH_UC_A && c <= CH_UC_F);
		endfunction

		function bit colour_ok();
			return hex_cnt == HEX_LEN_2 || hex_cnt == HEX_LEN_4 || hex_cnt == HEX_LEN_6;
		endfunction

		// Hold the token count at full scale and flag the overflow
		function void bump_tokens();
			if (tok_cnt == {COUNT_BITS{1'b1}})
				tok_over = 1'b1;
			else
				tok_cnt = tok_cnt + 1'b1;
		endfunction

		function void take_char(logic [CHAR_W-1:0] c);
			if (line_bad)
				return;
			case (phase)
				PH_START, PH_LEAD, PH_GAP: begin
					if (c == CH_SPACE) begin
						if (phase == PH_START)
							phase = PH_LEAD;
					end else if (c == CH_MINUS) begin
						bump_tokens();
						phase = PH_SIGN;
					end else if (is_dec(c)) begin
						bump_tokens();
						phase = PH_DIGITS;
					end else begin
						line_bad = 1'b1;
					end
				end
				PH_SIGN: begin
					if (is_dec(c))
						phase = PH_DIGITS;
					else
						line_bad = 1'b1;
				end
				PH_DIGITS: begin
					if (c == CH_COMMA)
						phase = PH_COMMA;
					else if (c == CH_SPACE)
						phase = PH_GAP;
					else if (!is_dec(c))
						line_bad = 1'b1;
				end
				PH_COMMA: begin
					if (c == CH_ZERO)
						phase = PH_ZERO;
					else
						line_bad = 1'b1;
				end
				PH_ZERO: begin
					if (c == CH_X) begin
						hex_cnt = '0;
						phase   = PH_HEX;
					end else begin
						line_bad = 1'b1;
					end
				end
				PH_HEX: begin
					if (is_hex(c)) begin
						if (hex_cnt != HEX_SAT)
							hex_cnt = hex_cnt + 1'b1;
					end else if (c == CH_SPACE && colour_ok()) begin
						phase = PH_GAP;
					end else begin
						line_bad = 1'b1;
					end
				end
				default: line_bad = 1'b1;
			endcase
		endfunction

		function bit ends_clean();
			case (phase)
				PH_START, PH_DIGITS, PH_GAP: return 1'b1;
				PH_HEX:                      return colour_ok();
				default:                     return 1'b0;
			endcase
		endfunction

		// Close the line: grade it, advance the row count, queue the verdict
		function void close_line();
			verdict_t v;
			if (line_bad || !ends_clean())
				v.status = ST_SYNTAX;
			else if (tok_over)
				v.status = ST_TOO_MANY;
			else if (row_cnt != 0 && tok_cnt != first_width)
				v.status = ST_MISMATCH;
			else
				v.status = ST_OK;
			if (v.status == ST_OK) begin
				if (row_cnt == 0)
					first_width = tok_cnt;
				if (row_cnt != {ROW_BITS{1'b1}})
					row_cnt = row_cnt + 1'b1;
			end
			v.columns = tok_cnt;
			v.rows    = row_cnt;
			verdict_q.push_back(v);
			reset_line();
		endfunction

		function void note_item(logic [OP_W-1:0] op, logic [CHAR_W-1:0] c);
			case (op)
				OP_CHAR: take_char(c);
				OP_EOL:  close_line();
				OP_NEW: begin
					reset_line();
					first_width = '0;
					row_cnt     = '0;
				end
				default: ;
			endcase
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$display("%0t: line result %0d, %s mismatch: expected %0d, actual %0d",
					$time, checked, what, want, got);
		endfunction

		function void check_verdict(logic [STATUS_W-1:0] st, logic [COLUMNS_W-1:0] cols,
			logic [ROWS_W-1:0] rws);
			verdict_t want;
			checked++;
			if (verdict_q.size() == 0) begin
				flag("unexpected result, status", 'x, st);
				return;
			end
			want = verdict_q.pop_front();
			seen[want.status]++;
			if (st !== want.status)
				flag("status", want.status, st);
			if (cols !== want.columns)
				flag("columns", want.columns, cols);
			if (rws !== want.rows)
				flag("rows", want.rows, rws);
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block under test
	// ------------------------------------------------------------------------
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      operation = OP_CHAR;
	logic [CHAR_W-1:0]    char_code = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [COLUMNS_W-1:0] columns;
	logic [ROWS_W-1:0]    rows;

	bit                   idle_enable = 1'b1;
	int                   stall_left  = 0;
	int                   quiet_cycles = 0;
	int                   items_sent  = 0;
	logic [CHAR_W-1:0]    line_buf[$];
	line_verdict_board    board = new();

	always #2 clk = ~clk;

	map_line_token_validator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.columns   (columns),
		.rows      (rows)
	);

	// ------------------------------------------------------------------------
	// Result-side backpressure: random stall bursts while idling is enabled;
	// a running burst drains even after idling is switched off.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left = stall_left - 1;
		else if (idle_enable && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 7);
		out_stall <= (stall_left > 0);
	end

	// ------------------------------------------------------------------------
	// Monitor and watchdog. Sample both channels at the edge; a transfer is
	// valid high with stall low. The watchdog counts edges with no transfer on
	// either side and ends the run when the count reaches its limit.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_item(operation, char_code);
			if (out_valid && !out_stall)
				board.check_verdict(status, columns, rows);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d cycles without a transfer",
					$time, quiet_cycles);
				$display("map_line_token_validator_core test failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Item driver
	// ------------------------------------------------------------------------

	// Present one item and hold it until the block takes the transfer.
	// An idle burst may drop valid first.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch);
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		char_code <= ch;
		do @(posedge clk); while (in_stall);
		if (op != OP_IGNORED)
			items_sent++;
	endtask

	// Send the buffered line, then end it; the unused char_code is random
	task automatic send_line();
		foreach (line_buf[i])
			send_item(OP_CHAR, line_buf[i]);
		send_item(OP_EOL, CHAR_W'($urandom));
	endtask

	task automatic start_map();
		send_item(OP_NEW, CHAR_W'($urandom));
	endtask

	// ------------------------------------------------------------------------
	// Line builders
	// ------------------------------------------------------------------------
	function automatic void load_text(input string s);
		line_buf.delete();
		foreach (s[i])
			line_buf.push_back(s[i]);
	endfunction

	function automatic logic [CHAR_W-1:0] rand_dec();
		return CH_ZERO + CHAR_W'($urandom_range(0, 9));
	endfunction

	function automatic logic [CHAR_W-1:0] rand_hex();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return CH_ZERO + CHAR_W'(v);
		return ($urandom_range(0, 1) ? CH_UC_A : CH_LC_A) + CHAR_W'(v - 10);
	endfunction

	// Append one token; hex_len 0 leaves the colour suffix off
	function automatic void add_token(input int hex_len);
		if ($urandom_range(0, 2) == 0)
			line_buf.push_back(CH_MINUS);
		repeat ($urandom_range(1, 4))
			line_buf.push_back(rand_dec());
		if (hex_len > 0) begin
			line_buf.push_back(CH_COMMA);
			line_buf.push_back(CH_ZERO);
			line_buf.push_back(CH_X);
			repeat (hex_len)
				line_buf.push_back(rand_hex());
		end
	endfunction

	function automatic int good_hex_len();
		case ($urandom_range(0, 4))
			0, 1:    return 0;
			2:       return 2;
			3:       return 4;
			default: return 6;
		endcase
	endfunction

	function automatic int bad_hex_len();
		case ($urandom_range(0, 4))
			0:       return 1;
			1:       return 3;
			2:       return 5;
			3:       return 7;
			default: return 8;
		endcase
	endfunction

	// Well-formed line of ntok tokens with random spacing and content
	function automatic void build_line(input int ntok);
		line_buf.delete();
		if (ntok > 0 && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SPACE);
		for (int i = 0; i < ntok; i++) begin
			if (i > 0)
				repeat ($urandom_range(1, 3)) line_buf.push_back(CH_SPACE);
			add_token(good_hex_len());
		end
		if (ntok > 0 && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SPACE);
	endfunction

	// Damage the buffered line in one of several ways
	function automatic void break_line();
		int pos;
		pos = (line_buf.size() == 0) ? 0 : $urandom_range(0, line_buf.size() - 1);
		case ($urandom_range(0, 4))
			0: begin
				if (line_buf.size() == 0)
					line_buf.push_back(CHAR_W'($urandom));
				else
					line_buf[pos] = CHAR_W'($urandom);
			end
			1: line_buf.insert(pos, CHAR_W'($urandom));
			2: while (line_buf.size() > pos) void'(line_buf.pop_back());
			3: begin
				// end the line on a bare comma or on ",0"
				line_buf.push_back(CH_COMMA);
				if ($urandom_range(0, 1))
					line_buf.push_back(CH_ZERO);
			end
			default: begin
				if (line_buf.size() != 0)
					line_buf.push_back(CH_SPACE);
				add_token(bad_hex_len());
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int map_width;
		int pick;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: empty row as first row, dropped operation,
		// leading and trailing spaces, lone sign, spaces only, line ending
		// after the comma or after ",0", six-digit colour, NUL character.
		send_item(OP_IGNORED, 8'hFF);
		load_text("");
		send_line();
		start_map();
		load_text(" -12,0xaF ");
		send_line();
		load_text("-");
		send_line();
		load_text("  ");
		send_line();
		load_text("5,");
		send_line();
		load_text("5,0");
		send_line();
		load_text("9,0xC3d4E5");
		send_line();
		line_buf.delete();
		line_buf.push_back(8'h00);
		send_line();

		// Random lines: mostly well-formed rows of the current map width,
		// some off-width rows, broken rows, noise and new maps.
		map_width = $urandom_range(1, 5);
		start_map();
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 15) == 0)
				idle_enable = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				build_line(map_width);
				send_line();
			end else if (pick < 70) begin
				build_line($urandom_range(0, 6));
				send_line();
			end else if (pick < 85) begin
				build_line(map_width);
				break_line();
				send_line();
			end else if (pick < 93) begin
				repeat ($urandom_range(1, 4))
					send_item(OP_W'($urandom), CHAR_W'($urandom));
			end else begin
				map_width = $urandom_range(0, 5);
				start_map();
			end
		end

		// Final stretch without idling: empty rows, a mismatched row, a
		// broken row, then a fresh map of well-formed rows back to back.
		idle_enable = 1'b0;
		start_map();
		repeat (3)
			send_item(OP_EOL, CHAR_W'($urandom));
		load_text("3");
		send_line();
		load_text("1 -");
		send_line();
		map_width = $urandom_range(1, 3);
		start_map();
		repeat (4) begin
			build_line(map_width);
			send_line();
		end
		in_valid <= 1'b0;

		// Drain outstanding verdicts, then let the pipeline settle
		do @(posedge clk); while (board.pending() != 0);
		repeat (LATENCY + 4) @(posedge clk);

		$display("Sent %0d items; checked %0d line results (ok %0d, syntax %0d, mismatch %0d, too many %0d).",
			items_sent, board.checked, board.seen[ST_OK], board.seen[ST_SYNTAX],
			board.seen[ST_MISMATCH], board.seen[ST_TOO_MANY]);
		$display("Covered corner lines, random good and broken lines, noise and map restarts; %0d mismatches.",
			board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("map_line_token_validator_core test passed");
		else
			$display("map_line_token_validator_core test failed");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/mltv_pkg.sv
hw/rtl/mltv_parse.sv
hw/rtl/map_line_token_validator_core.sv
dv/tb_map_line_token_validator_core.sv
